// ----- hdl/d2cp_pkg.sv -----
// constants shared by the 2d copy segment planner
`default_nettype none
package d2cp_pkg;

    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned Q_BITS    = 23;

    localparam logic [31:0] MAX_ROWS       = 32'd5242880;
    localparam logic [31:0] BURST_ROWS     = 32'd32768;
    localparam logic [47:0] CHUNK_BYTES    = 48'h0000_0400_0000;
    localparam logic [47:0] ONE_ADDR_LIMIT = 48'h0000_0800_0000;
    localparam logic [48:0] VA_RANGE_RESET = 49'h1_0000_0000_0000;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PITCH     = 3'd1;
    localparam logic [2:0] ST_ZERO      = 3'd2;
    localparam logic [2:0] ST_HEIGHT    = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;
    localparam logic [2:0] ST_DONE_OVER = 3'd5;

endpackage
`default_nettype wire

// ----- hdl/dma_2d_copy_segment_planner.sv -----
// 2d copy segment planner: pipelined divider, address advance and segment shaping
//
//  channel | ports                     | direction | beat
//  cfg     | cfg_valid/ready           | in        | va_range_size write
//  s       | s_valid/ready + s_*       | in        | one copy request
//  m       | m_valid/ready + m_*       | out       | one segment plan
//
// one request per cycle sustained while the m channel is not stalled
// the pipe is an input register, the 64-step restoring divider, one quotient bit per stage,
// then one stage each for status/partial products, product sum, address add
// synchronous active-low reset clears the valid bits and sets the range register to VA_RANGE_RESET
// a stall on m freezes every stage at once, so nothing is lost or repeated
`default_nettype none
module dma_2d_copy_segment_planner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [48:0] cfg_va_range_size,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_src_addr,
    input  wire logic [63:0] s_dst_addr,
    input  wire logic [47:0] s_src_pitch,
    input  wire logic [47:0] s_dst_pitch,
    input  wire logic [47:0] s_row_width,
    input  wire logic [31:0] s_row_count,
    input  wire logic [63:0] s_bytes_done,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [63:0]      m_seg_src_addr,
    output logic [63:0]      m_seg_dst_addr,
    output logic [47:0]      m_seg_src_pitch,
    output logic [47:0]      m_seg_dst_pitch,
    output logic [47:0]      m_seg_width,
    output logic [15:0]      m_seg_rows
);

    // payload carried through the divider
    typedef struct packed {
        logic [63:0] src;
        logic [63:0] dst;
        logic [47:0] sp;
        logic [47:0] dp;
        logic [47:0] w;
        logic [31:0] h;
        logic [2:0]  pre;   // status from the checks ahead of the division
        logic [63:0] num;   // dividend shifting out, quotient shifting in
        logic [47:0] rem;
    } div_t;

    logic [48:0] va_range_reg;
    logic        en;

    // whole pipe advances unless the output beat is held
    assign en        = ~m_valid | m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_range_reg <= d2cp_pkg::VA_RANGE_RESET;
        end else if (cfg_valid) begin
            va_range_reg <= cfg_va_range_size;
        end
    end

    // input checks, in priority order
    logic [2:0] pre_next;
    always_comb begin
        if (s_row_width > s_dst_pitch || s_row_width > s_src_pitch) begin
            pre_next = d2cp_pkg::ST_PITCH;
        end else if (s_row_width == 48'd0 || s_row_count == 32'd0) begin
            pre_next = d2cp_pkg::ST_ZERO;
        end else if (s_row_count > d2cp_pkg::MAX_ROWS) begin
            pre_next = d2cp_pkg::ST_HEIGHT;
        end else if ({1'b0, s_row_width} >= va_range_reg) begin
            pre_next = d2cp_pkg::ST_RANGE;
        end else begin
            pre_next = d2cp_pkg::ST_OK;
        end
    end

    div_t                     stg_reg [0:d2cp_pkg::DIV_STEPS];
    logic [d2cp_pkg::DIV_STEPS:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0] <= '{src: s_src_addr, dst: s_dst_addr, sp: s_src_pitch,
                            dp: s_dst_pitch, w: s_row_width, h: s_row_count,
                            pre: pre_next, num: s_bytes_done, rem: 48'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[d2cp_pkg::DIV_STEPS-1:0], s_valid};
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar g = 0; g < d2cp_pkg::DIV_STEPS; g++) begin : g_div
        logic [48:0] trial;
        div_t        stg_next;
        always_comb begin
            stg_next = stg_reg[g];
            trial    = {stg_reg[g].rem, stg_reg[g].num[63]};
            stg_next.num = {stg_reg[g].num[62:0], 1'b0};
            if (trial >= {1'b0, stg_reg[g].w}) begin
                trial           = trial - {1'b0, stg_reg[g].w};
                stg_next.num[0] = 1'b1;
            end
            stg_next.rem = trial[47:0];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[g+1] <= stg_next;
            end
        end
    end

    // stage m1: final status, remaining width, partial products
    div_t        dq;
    logic [63:0] quo;
    logic [2:0]  st_next;
    assign dq  = stg_reg[d2cp_pkg::DIV_STEPS];
    assign quo = dq.num;

    always_comb begin
        if (dq.pre != d2cp_pkg::ST_OK) begin
            st_next = dq.pre;
        end else if (quo > {32'd0, dq.h} || (quo == {32'd0, dq.h} && dq.rem != 48'd0)) begin
            st_next = d2cp_pkg::ST_DONE_OVER;
        end else begin
            st_next = d2cp_pkg::ST_OK;
        end
    end

    logic        m1_vld_reg;
    logic [2:0]  m1_st_reg;
    logic [63:0] m1_src_reg, m1_dst_reg;
    logic [47:0] m1_sp_reg, m1_dp_reg, m1_w_reg, m1_r_reg, m1_left_reg;
    logic [31:0] m1_tail_reg;
    logic [46:0] m1_psl_reg, m1_psh_reg, m1_pdl_reg, m1_pdh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= vld_reg[d2cp_pkg::DIV_STEPS];
        end
    end

    // an ok status bounds the quotient by MAX_ROWS, so its low bits suffice
    always_ff @(posedge aclk) begin
        if (en) begin
            m1_st_reg   <= st_next;
            m1_src_reg  <= dq.src;
            m1_dst_reg  <= dq.dst;
            m1_sp_reg   <= dq.sp;
            m1_dp_reg   <= dq.dp;
            m1_w_reg    <= dq.w;
            m1_r_reg    <= dq.rem;
            m1_left_reg <= dq.w - dq.rem;
            m1_tail_reg <= dq.h - quo[31:0];
            m1_psl_reg  <= quo[d2cp_pkg::Q_BITS-1:0] * dq.sp[23:0];
            m1_psh_reg  <= quo[d2cp_pkg::Q_BITS-1:0] * dq.sp[47:24];
            m1_pdl_reg  <= quo[d2cp_pkg::Q_BITS-1:0] * dq.dp[23:0];
            m1_pdh_reg  <= quo[d2cp_pkg::Q_BITS-1:0] * dq.dp[47:24];
        end
    end

    // stage m2: product sums and segment shape
    logic [47:0] shp_w, shp_sp, shp_dp;
    logic [31:0] rows_full;
    logic [15:0] rows_clamped;

    always_comb begin
        shp_w  = m1_w_reg;
        shp_sp = m1_sp_reg;
        shp_dp = m1_dp_reg;
        if (m1_w_reg <= d2cp_pkg::ONE_ADDR_LIMIT) begin
            if (m1_r_reg != 48'd0) begin
                shp_w     = m1_left_reg;
                rows_full = 32'd1;
            end else begin
                rows_full = m1_tail_reg;
            end
        end else if (m1_left_reg < d2cp_pkg::ONE_ADDR_LIMIT) begin
            shp_w     = m1_left_reg;
            rows_full = 32'd1;
        end else begin
            // run of 64 MiB chunks laid end to end
            shp_w     = d2cp_pkg::CHUNK_BYTES;
            shp_sp    = d2cp_pkg::CHUNK_BYTES;
            shp_dp    = d2cp_pkg::CHUNK_BYTES;
            rows_full = {10'd0, m1_left_reg[47:26]};
        end
        if (rows_full > d2cp_pkg::BURST_ROWS) begin
            rows_clamped = d2cp_pkg::BURST_ROWS[15:0];
        end else begin
            rows_clamped = rows_full[15:0];
        end
    end

    logic        m2_vld_reg;
    logic [2:0]  m2_st_reg;
    logic [63:0] m2_src_reg, m2_dst_reg, m2_ps_reg, m2_pd_reg;
    logic [47:0] m2_r_reg, m2_w_reg, m2_sp_reg, m2_dp_reg;
    logic [15:0] m2_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (en) begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_st_reg   <= m1_st_reg;
            m2_src_reg  <= m1_src_reg;
            m2_dst_reg  <= m1_dst_reg;
            m2_ps_reg   <= {17'd0, m1_psl_reg} + {m1_psh_reg[39:0], 24'd0};
            m2_pd_reg   <= {17'd0, m1_pdl_reg} + {m1_pdh_reg[39:0], 24'd0};
            m2_r_reg    <= m1_r_reg;
            m2_w_reg    <= shp_w;
            m2_sp_reg   <= shp_sp;
            m2_dp_reg   <= shp_dp;
            m2_rows_reg <= rows_clamped;
        end
    end

    // stage m3: address advance and output register, zeroed on error
    logic ok_m2;
    assign ok_m2 = (m2_st_reg == d2cp_pkg::ST_OK);

    logic        out_vld_reg;
    logic [2:0]  out_st_reg;
    logic [63:0] out_src_reg, out_dst_reg;
    logic [47:0] out_sp_reg, out_dp_reg, out_w_reg;
    logic [15:0] out_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_st_reg   <= m2_st_reg;
            out_src_reg  <= ok_m2 ? m2_src_reg + m2_ps_reg + {16'd0, m2_r_reg} : 64'd0;
            out_dst_reg  <= ok_m2 ? m2_dst_reg + m2_pd_reg + {16'd0, m2_r_reg} : 64'd0;
            out_sp_reg   <= ok_m2 ? m2_sp_reg : 48'd0;
            out_dp_reg   <= ok_m2 ? m2_dp_reg : 48'd0;
            out_w_reg    <= ok_m2 ? m2_w_reg : 48'd0;
            out_rows_reg <= ok_m2 ? m2_rows_reg : 16'd0;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_status        = out_st_reg;
    assign m_seg_src_addr  = out_src_reg;
    assign m_seg_dst_addr  = out_dst_reg;
    assign m_seg_src_pitch = out_sp_reg;
    assign m_seg_dst_pitch = out_dp_reg;
    assign m_seg_width     = out_w_reg;
    assign m_seg_rows      = out_rows_reg;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != d2cp_pkg::ST_OK) |->
        (m_seg_rows == 16'd0 && m_seg_width == 48'd0 && m_seg_src_addr == 64'd0))
        else $error("error beat carries non-zero segment");
    a_rows_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_seg_rows <= d2cp_pkg::BURST_ROWS[15:0]))
        else $error("segment rows above burst limit");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready not tied to output stall");
    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m1_vld_reg) && $stable(m2_vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
